// File: rtl/http_header_block_tokenizer_unit_macros.svh
`ifndef HTTP_HEADER_BLOCK_TOKENIZER_UNIT_MACROS_SVH
`define HTTP_HEADER_BLOCK_TOKENIZER_UNIT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define HHBT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define HHBT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/hhbt_pkg.sv
package hhbt_pkg;

	localparam int OFFSET_BITS = 12;
	localparam int CFG_BITS    = 12;
	localparam int CMP_BITS    = (OFFSET_BITS > CFG_BITS) ? OFFSET_BITS : CFG_BITS;

	localparam logic [CFG_BITS-1:0]    CFG_RESET  = CFG_BITS'(255);
	localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	typedef enum logic [2:0] {
		PH_START,
		PH_KEY,
		PH_COLON,
		PH_SPACE,
		PH_VALUE,
		PH_CR,
		PH_LF,
		PH_END_CR
	} phase_t;

	typedef enum logic [1:0] {
		ROLE_DELIM,
		ROLE_KEY,
		ROLE_VALUE
	} role_t;

	typedef enum logic [2:0] {
		ERR_NONE,
		ERR_KEY_CRLF,
		ERR_NO_SPACE,
		ERR_TOO_LONG,
		ERR_CR_NO_LF,
		ERR_END_CR_NO_LF
	} err_t;

	typedef struct packed {
		role_t role;
		logic  line_done;
		logic  block_done;
		err_t  err;
	} hhbt_res_t;

endpackage

// File: rtl/hhbt_in_if.sv
interface hhbt_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_byte;

	modport source (output valid, kind, data_byte, input ready);
	modport sink   (input valid, kind, data_byte, output ready);
endinterface

// File: rtl/hhbt_out_if.sv
interface hhbt_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_out;
	logic [1:0] byte_role;
	logic       line_done;
	logic       block_done;
	logic       error_flag;
	logic [2:0] error_code;

	modport source (output valid, byte_out, byte_role, line_done, block_done,
		error_flag, error_code, input ready);
	modport sink   (input valid, byte_out, byte_role, line_done, block_done,
		error_flag, error_code, output ready);
endinterface

// File: rtl/hhbt_parse.sv
module hhbt_parse
	import hhbt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                kind,
	input  logic [7:0]          data_byte,
	input  logic [CFG_BITS-1:0] max_value_offset,
	output hhbt_res_t           res
);

	phase_t                 phase_q, phase_d;
	logic [OFFSET_BITS-1:0] offset_q, offset_d;
	err_t                   err_q, err_d;

	logic [CMP_BITS-1:0] off_ext;
	logic [CMP_BITS-1:0] cfg_ext;
	logic [CMP_BITS-1:0] mask_ext;
	logic [CMP_BITS-1:0] limit_ext;

	assign off_ext   = CMP_BITS'(offset_q);
	assign cfg_ext   = CMP_BITS'(max_value_offset);
	assign mask_ext  = CMP_BITS'(OFFSET_MAX);
	assign limit_ext = (cfg_ext < mask_ext) ? cfg_ext : mask_ext;

	always_comb begin
		phase_d        = phase_q;
		offset_d       = offset_q;
		err_d          = err_q;
		res.role       = ROLE_DELIM;
		res.line_done  = 1'b0;
		res.block_done = 1'b0;
		if (kind) begin
			phase_d  = PH_START;
			offset_d = '0;
			err_d    = ERR_NONE;
		end else if (err_q == ERR_NONE) begin
			case (phase_q)
				PH_START: begin
					if (!(data_byte inside {CH_CR, CH_LF})) begin
						phase_d  = PH_KEY;
						res.role = ROLE_KEY;
					end
				end
				PH_KEY: begin
					if (data_byte == CH_COLON) begin
						phase_d = PH_COLON;
					end else if (data_byte inside {CH_CR, CH_LF}) begin
						err_d = ERR_KEY_CRLF;
					end else begin
						res.role = ROLE_KEY;
					end
				end
				PH_COLON: begin
					if (data_byte == CH_SPACE) begin
						phase_d = PH_SPACE;
					end else begin
						err_d = ERR_NO_SPACE;
					end
				end
				PH_SPACE: begin
					// first value byte is taken whatever it is
					phase_d  = PH_VALUE;
					offset_d = '0;
					res.role = ROLE_VALUE;
				end
				PH_VALUE: begin
					if (data_byte == CH_CR) begin
						phase_d = PH_CR;
					end else if (off_ext >= limit_ext) begin
						err_d = ERR_TOO_LONG;
					end else begin
						offset_d = offset_q + 1'b1;
						res.role = ROLE_VALUE;
					end
				end
				PH_CR: begin
					if (data_byte == CH_LF) begin
						phase_d       = PH_LF;
						res.line_done = 1'b1;
					end else begin
						err_d = ERR_CR_NO_LF;
					end
				end
				PH_LF: begin
					if (data_byte == CH_CR) begin
						phase_d = PH_END_CR;
					end else begin
						phase_d  = PH_KEY;
						res.role = ROLE_KEY;
					end
				end
				PH_END_CR: begin
					if (data_byte == CH_LF) begin
						phase_d        = PH_START;
						offset_d       = '0;
						res.block_done = 1'b1;
					end else begin
						err_d = ERR_END_CR_NO_LF;
					end
				end
				default: begin
					phase_d = PH_START;
				end
			endcase
		end
		res.err = err_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			offset_q <= '0;
			err_q    <= ERR_NONE;
		end else if (step) begin
			phase_q  <= phase_d;
			offset_q <= offset_d;
			err_q    <= err_d;
		end
	end

endmodule

// File: rtl/http_header_block_tokenizer_unit.sv
// Channel   Port      Direction  Payload
// input     byte_in   sink       kind, data_byte
// result    result    source     byte_out, byte_role, line_done, block_done,
//                                error_flag, error_code
// config    cfg_wr_*  write      max_value_offset (12 bits)
//
// One byte per cycle sustained while the receiver keeps result ready; an input byte goes
// through the input register, then the parse step into the result register.
// The parse state machine and value offset counter update once per item.
// Reset clears phase, offset, error and the limit (to 255); no clearing pass.
// A stalled result holds; the input register still fills behind it.
`include "http_header_block_tokenizer_unit_macros.svh"

module http_header_block_tokenizer_unit
	import hhbt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	hhbt_in_if.sink             byte_in,
	hhbt_out_if.source          result,
	input  logic                cfg_wr_en,
	input  logic [CFG_BITS-1:0] cfg_wr_data
);

	logic [CFG_BITS-1:0] max_offset_q;

	logic       valid_s1;
	logic       kind_s1;
	logic [7:0] byte_s1;
	logic       s1_move;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	hhbt_res_t  out_res_q;
	hhbt_res_t  step_res;

	assign s1_move      = valid_s1 && (!out_valid_q || result.ready);
	assign byte_in.ready = !valid_s1 || s1_move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_offset_q <= CFG_RESET;
		end else if (cfg_wr_en) begin
			max_offset_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			valid_s1 <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.valid && byte_in.ready) begin
			kind_s1 <= byte_in.kind;
			byte_s1 <= byte_in.data_byte;
		end
	end

	hhbt_parse u_parse (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (s1_move),
		.kind             (kind_s1),
		.data_byte        (byte_s1),
		.max_value_offset (max_offset_q),
		.res              (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// advance the result register on each parse step
	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_byte_q <= byte_s1;
			out_res_q  <= step_res;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.byte_out   = out_byte_q;
	assign result.byte_role  = out_res_q.role;
	assign result.line_done  = out_res_q.line_done;
	assign result.block_done = out_res_q.block_done;
	assign result.error_flag = (out_res_q.err != ERR_NONE);
	assign result.error_code = out_res_q.err;

	`HHBT_ASSERT_NEXT(a_step_fills_result, s1_move, out_valid_q, "parse step left no result")
	`HHBT_ASSERT_NOW(a_one_pulse, out_valid_q,
		!(out_res_q.line_done && out_res_q.block_done), "line and block done together")
	`HHBT_ASSERT_NOW(a_no_role_on_error, out_valid_q && out_res_q.err != ERR_NONE,
		out_res_q.role == ROLE_DELIM && !out_res_q.line_done && !out_res_q.block_done,
		"tagged byte or pulse while in error")

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench
	import hhbt_pkg::*;
();

	localparam int QUIET_LIMIT = 2000;
	localparam int PLAN_ROWS   = 26;
	localparam int PHASES      = 7;
	localparam int PHASE_ITEMS = 180;

	typedef struct packed {
		logic [7:0] echo;
		role_t      role;
		logic       line_end;
		logic       block_end;
		logic       err_on;
		err_t       err;
	} token_t;

	typedef struct packed {
		bit         restart;
		logic [7:0] b;
		bit         typed;
		role_t      role;
		logic       line_end;
		logic       block_end;
		err_t       err;
	} plan_row_t;

	typedef enum {RX_OPEN, RX_ALTERNATE, RX_RANDOM, RX_CHOKED} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_BITS-1:0] cfg_wr_data;

	hhbt_in_if  byte_in_ch ();
	hhbt_out_if result_ch ();

	http_header_block_tokenizer_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_in    (byte_in_ch),
		.result     (result_ch),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Parser shadow state
	logic [CFG_BITS-1:0]    value_limit_reg = CFG_RESET;
	phase_t                 pp_phase  = PH_START;
	logic [OFFSET_BITS-1:0] pp_offset = '0;
	err_t                   pp_err    = ERR_NONE;

	token_t expected_tokens[$];
	int     fail_count  = 0;
	int     live_items  = 0;
	int     burst_left  = 0;
	int     quiet_cycles = 0;
	bit     fault_on    = 1'b0;

	plan_row_t plan [PLAN_ROWS] = '{
		'{1'b0, CH_CR,    1'b1, ROLE_DELIM, 1'b0, 1'b0, ERR_NONE},
		'{1'b0, CH_LF,    1'b1, ROLE_DELIM, 1'b0, 1'b0, ERR_NONE},
		'{1'b0, CH_COLON, 1'b1, ROLE_KEY,   1'b0, 1'b0, ERR_NONE},
		'{1'b0, 8'hFF,    1'b1, ROLE_KEY,   1'b0, 1'b0, ERR_NONE},
		'{1'b0, CH_COLON, 1'b0, ROLE_DELIM, 1'b0, 1'b0, ERR_NONE},
		'{1'b0, CH_SPACE, 1'b0, ROLE_DELIM, 1'b0, 1'b0, ERR_NONE},
		'{1'b0, CH_CR,    1'b1, ROLE_VALUE, 1'b0, 1'b0, ERR_NONE},
		'{1'b0, 8'h00,    1'b1, ROLE_VALUE, 1'b0, 1'b0, ERR_NONE},
		'{1'b0, CH_CR,    1'b0, ROLE_DELIM, 1'b0, 1'b0, ERR_NONE},
		'{1'b0, CH_LF,    1'b1, ROLE_DELIM, 1'b1, 1'b0, ERR_NONE},
		'{1'b0, CH_LF,    1'b1, ROLE_KEY,   1'b0, 1'b0, ERR_NONE},
		'{1'b0, CH_COLON, 1'b0, ROLE_DELIM, 1'b0, 1'b0, ERR_NONE},
		'{1'b0, CH_SPACE, 1'b0, ROLE_DELIM, 1'b0, 1'b0, ERR_NONE},
		'{1'b0, 8'h7F,    1'b0, ROLE_DELIM, 1'b0, 1'b0, ERR_NONE},
		'{1'b0, CH_CR,    1'b0, ROLE_DELIM, 1'b0, 1'b0, ERR_NONE},
		'{1'b0, CH_LF,    1'b1, ROLE_DELIM, 1'b1, 1'b0, ERR_NONE},
		'{1'b0, CH_CR,    1'b0, ROLE_DELIM, 1'b0, 1'b0, ERR_NONE},
		'{1'b0, CH_LF,    1'b1, ROLE_DELIM, 1'b0, 1'b1, ERR_NONE},
		'{1'b0, 8'h6B,    1'b0, ROLE_DELIM, 1'b0, 1'b0, ERR_NONE},
		'{1'b0, CH_LF,    1'b1, ROLE_DELIM, 1'b0, 1'b0, ERR_KEY_CRLF},
		'{1'b0, 8'h41,    1'b1, ROLE_DELIM, 1'b0, 1'b0, ERR_KEY_CRLF},
		'{1'b1, 8'hA5,    1'b1, ROLE_DELIM, 1'b0, 1'b0, ERR_NONE},
		'{1'b0, 8'h6B,    1'b0, ROLE_DELIM, 1'b0, 1'b0, ERR_NONE},
		'{1'b0, CH_COLON, 1'b0, ROLE_DELIM, 1'b0, 1'b0, ERR_NONE},
		'{1'b0, 8'h09,    1'b1, ROLE_DELIM, 1'b0, 1'b0, ERR_NO_SPACE},
		'{1'b1, 8'h5A,    1'b1, ROLE_DELIM, 1'b0, 1'b0, ERR_NONE}
	};

	function automatic token_t parse_byte(input bit restart, input logic [7:0] b);
		token_t t;
		logic [CMP_BITS-1:0] lim;
		lim = (CMP_BITS'(value_limit_reg) < CMP_BITS'(OFFSET_MAX)) ?
			CMP_BITS'(value_limit_reg) : CMP_BITS'(OFFSET_MAX);
		t.echo      = b;
		t.role      = ROLE_DELIM;
		t.line_end  = 1'b0;
		t.block_end = 1'b0;
		if (restart) begin
			pp_phase  = PH_START;
			pp_offset = '0;
			pp_err    = ERR_NONE;
		end else if (pp_err == ERR_NONE) begin
			case (pp_phase)
				PH_START: begin
					if (b != CH_CR && b != CH_LF) begin
						pp_phase = PH_KEY;
						t.role   = ROLE_KEY;
					end
				end
				PH_KEY: begin
					if (b == CH_COLON)
						pp_phase = PH_COLON;
					else if (b == CH_CR || b == CH_LF)
						pp_err = ERR_KEY_CRLF;
					else
						t.role = ROLE_KEY;
				end
				PH_COLON: begin
					if (b == CH_SPACE)
						pp_phase = PH_SPACE;
					else
						pp_err = ERR_NO_SPACE;
				end
				PH_SPACE: begin
					pp_phase  = PH_VALUE;
					pp_offset = '0;
					t.role    = ROLE_VALUE;
				end
				PH_VALUE: begin
					// CR closes the value before the length check
					if (b == CH_CR) begin
						pp_phase = PH_CR;
					end else if (CMP_BITS'(pp_offset) >= lim) begin
						pp_err = ERR_TOO_LONG;
					end else begin
						pp_offset = pp_offset + 1'b1;
						t.role    = ROLE_VALUE;
					end
				end
				PH_CR: begin
					if (b == CH_LF) begin
						pp_phase   = PH_LF;
						t.line_end = 1'b1;
					end else begin
						pp_err = ERR_CR_NO_LF;
					end
				end
				PH_LF: begin
					if (b == CH_CR) begin
						pp_phase = PH_END_CR;
					end else begin
						pp_phase = PH_KEY;
						t.role   = ROLE_KEY;
					end
				end
				PH_END_CR: begin
					if (b == CH_LF) begin
						pp_phase    = PH_START;
						pp_offset   = '0;
						t.block_end = 1'b1;
					end else begin
						pp_err = ERR_END_CR_NO_LF;
					end
				end
				default: pp_phase = PH_START;
			endcase
		end
		t.err    = pp_err;
		t.err_on = (pp_err != ERR_NONE);
		return t;
	endfunction

	function automatic logic [7:0] rand_key_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255));
		while (b == CH_CR || b == CH_LF || b == CH_COLON);
		return b;
	endfunction

	function automatic logic [7:0] rand_value_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255));
		while (b == CH_CR);
		return b;
	endfunction

	function automatic logic [7:0] maybe_space();
		return ($urandom_range(0, 11) == 0) ? 8'($urandom_range(0, 255)) : CH_SPACE;
	endfunction

	function automatic logic [7:0] maybe_lf();
		return ($urandom_range(0, 11) == 0) ? 8'($urandom_range(0, 255)) : CH_LF;
	endfunction

	function automatic int pick_value_len();
		int allowed;
		int r;
		allowed = int'(value_limit_reg) + 1;
		r = $urandom_range(0, 19);
		if (allowed <= 300 && r == 0)
			return allowed;
		if (allowed <= 300 && r == 1)
			return allowed + 1;
		return $urandom_range(1, (allowed < 12) ? allowed : 12);
	endfunction

	task automatic push_byte(input bit restart, input logic [7:0] b,
		input bit use_typed, input token_t typed_res);
		token_t predicted;
		int gap_len;
		if (burst_left == 0) begin
			gap_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			repeat (gap_len) begin
				@(negedge clk);
				byte_in_ch.valid <= 1'b0;
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 24);
		end
		@(negedge clk);
		byte_in_ch.valid     <= 1'b1;
		byte_in_ch.kind      <= restart;
		byte_in_ch.data_byte <= b;
		do @(posedge clk);
		while (!byte_in_ch.ready);
		if (restart || pp_err == ERR_NONE)
			live_items++;
		predicted = parse_byte(restart, b);
		expected_tokens.push_back(use_typed ? typed_res : predicted);
		burst_left--;
	endtask

	// Drop header bytes once the parser has latched an error
	task automatic send_data(input logic [7:0] b);
		logic [7:0] v;
		if (pp_err != ERR_NONE)
			return;
		v = (fault_on && $urandom_range(0, 59) == 0) ? 8'($urandom_range(0, 255)) : b;
		push_byte(1'b0, v, 1'b0, '0);
	endtask

	task automatic emit_line(input int vlen);
		int klen;
		klen = $urandom_range(1, 6);
		send_data(($urandom_range(0, 7) == 0) ? CH_COLON : rand_key_byte());
		repeat (klen - 1) send_data(rand_key_byte());
		send_data(CH_COLON);
		send_data(maybe_space());
		send_data(($urandom_range(0, 7) == 0) ? CH_CR : rand_value_byte());
		repeat (vlen - 1) send_data(rand_value_byte());
		send_data(CH_CR);
		send_data(maybe_lf());
	endtask

	task automatic recover();
		if (pp_err != ERR_NONE) begin
			repeat ($urandom_range(0, 2)) push_byte(1'b0, 8'($urandom_range(0, 255)), 1'b0, '0);
			push_byte(1'b1, 8'($urandom_range(0, 255)), 1'b0, '0);
		end
	endtask

	task automatic emit_block();
		repeat ($urandom_range(0, 2)) send_data($urandom_range(0, 1) ? CH_CR : CH_LF);
		repeat ($urandom_range(0, 4)) emit_line(pick_value_len());
		send_data(CH_CR);
		send_data(maybe_lf());
		recover();
	endtask

	task automatic set_value_limit(input logic [CFG_BITS-1:0] v);
		@(negedge clk);
		byte_in_ch.valid <= 1'b0;
		while (expected_tokens.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		value_limit_reg = v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Receiver back-pressure, switching between patterns
	initial begin
		rx_mode_t rx_mode;
		int       rx_left;
		bit       rx_tick;
		result_ch.ready = 1'b0;
		rx_mode = RX_OPEN;
		rx_left = 0;
		rx_tick = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(16, 200);
			end
			rx_left--;
			rx_tick = !rx_tick;
			case (rx_mode)
				RX_OPEN:      result_ch.ready <= 1'b1;
				RX_ALTERNATE: result_ch.ready <= rx_tick;
				RX_RANDOM:    result_ch.ready <= ($urandom_range(0, 3) != 0);
				default:      result_ch.ready <= ($urandom_range(0, 11) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		token_t want;
		token_t got;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got.echo      = result_ch.byte_out;
			got.role      = role_t'(result_ch.byte_role);
			got.line_end  = result_ch.line_done;
			got.block_end = result_ch.block_done;
			got.err_on    = result_ch.error_flag;
			got.err       = err_t'(result_ch.error_code);
			if (expected_tokens.size() == 0) begin
				if (fail_count < 10)
					$display("%0t: result byte %02h with nothing pending", $time, got.echo);
				fail_count++;
			end else begin
				want = expected_tokens.pop_front();
				if (got.echo !== want.echo || got.role !== want.role
					|| got.line_end !== want.line_end || got.block_end !== want.block_end
					|| got.err_on !== want.err_on || got.err !== want.err) begin
					if (fail_count < 10)
						$display("%0t: expected byte %02h role %0d line %0b block %0b ",
							$time, want.echo, want.role, want.line_end, want.block_end,
							"flag %0b code %0d; got byte %02h role %0d line %0b block %0b ",
							want.err_on, want.err, got.echo, got.role, got.line_end,
							got.block_end, "flag %0b code %0d", got.err_on, got.err);
					fail_count++;
				end
			end
		end
	end

	// Hang guard: give up when no transfer happens for too long
	always @(posedge clk) begin
		if (!arst_n || (byte_in_ch.valid && byte_in_ch.ready)
			|| (result_ch.valid && result_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		logic [CFG_BITS-1:0] limit_plan [PHASES];
		token_t typed_tok;
		int phase_end;
		limit_plan = '{CFG_RESET, 12'd1, 12'd0, 12'd4095, 12'd0, 12'd3, CFG_RESET};
		limit_plan[4] = CFG_BITS'($urandom_range(1, 4095));
		arst_n               = 1'b0;
		cfg_wr_en            = 1'b0;
		cfg_wr_data          = '0;
		byte_in_ch.valid     = 1'b0;
		byte_in_ch.kind      = 1'b0;
		byte_in_ch.data_byte = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < PLAN_ROWS; i++) begin
			typed_tok.echo      = plan[i].b;
			typed_tok.role      = plan[i].role;
			typed_tok.line_end  = plan[i].line_end;
			typed_tok.block_end = plan[i].block_end;
			typed_tok.err_on    = (plan[i].err != ERR_NONE);
			typed_tok.err       = plan[i].err;
			push_byte(plan[i].restart, plan[i].b, plan[i].typed, typed_tok);
		end

		fault_on = 1'b1;
		for (int p = 0; p < PHASES; p++) begin
			if (p > 0)
				set_value_limit(limit_plan[p]);
			phase_end = live_items + PHASE_ITEMS;
			while (live_items < phase_end) begin
				if ($urandom_range(0, 7) == 0) begin
					repeat ($urandom_range(1, 8)) push_byte(1'b0, 8'($urandom_range(0, 255)),
						1'b0, '0);
					push_byte(1'b1, 8'($urandom_range(0, 255)), 1'b0, '0);
				end else begin
					emit_block();
				end
			end
		end

		@(negedge clk);
		byte_in_ch.valid <= 1'b0;
		while (expected_tokens.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
